### rtl/sprite_row_composite_mirror_macros.svh
// ----------------------------------------------------------------------------
// sprite_row_composite_mirror_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ROW_COMPOSITE_MIRROR_MACROS_SVH
`define SPRITE_ROW_COMPOSITE_MIRROR_MACROS_SVH

// same-cycle implication
`define SRCM_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRCM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/srcm_pkg.sv
// ----------------------------------------------------------------------------
// srcm_pkg
// Shared constants, codes and types of the sprite row compositor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srcm_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int COL_W      = 6;
	localparam int WIDTH_W    = 7;
	localparam int SYM_W      = 8;
	localparam int ROW_W      = 6;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [KIND_W-1:0] KIND_BASE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OVERLAY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMIT    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_LAST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OVL_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 3'd7;

	localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_WIDTH);

	// control broadcast to every buffer cell
	typedef struct packed {
		logic               wr;
		logic [COL_W-1:0]   wr_idx;
		logic [SYM_W-1:0]   wr_data;
		logic               shl;
		logic               shr;
		logic [WIDTH_W-1:0] width;
	} cell_ctrl_t;

endpackage

### rtl/srcm_if.sv
// ----------------------------------------------------------------------------
// srcm_in_if / srcm_out_if
// Valid/ready channels for input items and emitted cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srcm_in_if;
	import srcm_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic [SYM_W-1:0]  symbol;

	modport source (output valid, kind, row, col, symbol, input ready);
	modport sink   (input valid, kind, row, col, symbol, output ready);
endinterface

interface srcm_out_if;
	import srcm_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] out_col;
	logic [SYM_W-1:0] out_symbol;
	logic             out_last;

	modport source (output valid, out_col, out_symbol, out_last, input ready);
	modport sink   (input valid, out_col, out_symbol, out_last, output ready);
endinterface

### rtl/sprite_row_composite_mirror.sv
// Base and overlay words: one per cycle while input ready is high, written into
// the cell row at the next edge. Emit word: busy is registered, then the output
// register takes one cell per cycle unless stalled; cells rotate one place per word.
// Input ready is low while a row streams out. Reset clears control and presets the
// config registers; line buffer contents are undefined until written.
// ----------------------------------------------------------------------------
// sprite_row_composite_mirror
// Color-key sprite row compositor with horizontal mirror, top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_row_composite_mirror
	import srcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	srcm_in_if.sink               items,
	srcm_out_if.source            results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cell_ctrl_t       ctrl;
	logic [COL_W-1:0] tail_idx;
	logic [SYM_W-1:0] sym [MAX_WIDTH];
	logic [SYM_W-1:0] head;
	logic [SYM_W-1:0] tail;

	assign head = sym[0];
	assign tail = sym[tail_idx];

	srcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.items    (items),
		.results  (results),
		.head     (head),
		.tail     (tail),
		.ctrl     (ctrl),
		.tail_idx (tail_idx)
	);

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		logic [SYM_W-1:0] nxt;
		logic [SYM_W-1:0] prv;

		if (i == MAX_WIDTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = sym[i+1];
		end
		if (i == 0) begin : g_start
			assign prv = '0;
		end else begin : g_rest
			assign prv = sym[i-1];
		end

		srcm_cell u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.idx  (COL_W'(i)),
			.nxt  (nxt),
			.prv  (prv),
			.head (head),
			.tail (tail),
			.sym  (sym[i])
		);
	end

endmodule

### rtl/srcm_cell.sv
// ----------------------------------------------------------------------------
// srcm_cell
// One line buffer entry; written by index, rotates with its neighbors on emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcm_cell
	import srcm_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [COL_W-1:0] idx,
	input  logic [SYM_W-1:0] nxt,
	input  logic [SYM_W-1:0] prv,
	input  logic [SYM_W-1:0] head,
	input  logic [SYM_W-1:0] tail,
	output logic [SYM_W-1:0] sym
);

	logic [SYM_W-1:0] sym_q;
	logic             active;
	logic             is_last;
	logic             is_first;

	assign active   = {1'b0, idx} < ctrl.width;
	assign is_last  = {1'b0, idx} == (ctrl.width - WIDTH_W'(1));
	assign is_first = idx == '0;

	always_ff @(posedge clk) begin
		if (ctrl.wr && ctrl.wr_idx == idx) begin
			sym_q <= ctrl.wr_data;
		end else if (ctrl.shl && active) begin
			sym_q <= is_last ? head : nxt;
		end else if (ctrl.shr && active) begin
			sym_q <= is_first ? tail : prv;
		end
	end

	assign sym = sym_q;

endmodule

### rtl/srcm_ctrl.sv
// ----------------------------------------------------------------------------
// srcm_ctrl
// Config registers, item decode, emit sequencer and output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srcm_ctrl
	import srcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	srcm_in_if.sink               items,
	srcm_out_if.source            results,
	input  logic [SYM_W-1:0]      head,
	input  logic [SYM_W-1:0]      tail,
	output cell_ctrl_t            ctrl,
	output logic [COL_W-1:0]      tail_idx
);

	logic [WIDTH_W-1:0] bw_q;
	logic [7:0]         off_q;
	logic [ROW_W-1:0]   first_q;
	logic [ROW_W-1:0]   last_q;
	logic               ovl_en_q;
	logic               blend_q;
	logic               mirror_q;
	logic [SYM_W-1:0]   transp_q;

	logic               busy_q;
	logic [COL_W-1:0]   cnt_q;
	logic               out_v_q;
	logic [COL_W-1:0]   out_col_q;
	logic [SYM_W-1:0]   out_sym_q;
	logic               out_last_q;

	logic [WIDTH_W-1:0] width;
	logic               acc;
	logic signed [8:0]  target;
	logic               tgt_ok;
	logic               row_ok;
	logic               wr_base;
	logic               wr_ovl;
	logic               advance;
	logic               last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q     <= WIDTH_MAX;
			off_q    <= '0;
			first_q  <= '0;
			last_q   <= ROW_W'(63);
			ovl_en_q <= 1'b0;
			blend_q  <= 1'b1;
			mirror_q <= 1'b0;
			transp_q <= SYM_W'(32);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BASE_WIDTH:   bw_q     <= cfg_data[WIDTH_W-1:0];
				CFG_COL_OFFSET:   off_q    <= cfg_data;
				CFG_REGION_FIRST: first_q  <= cfg_data[ROW_W-1:0];
				CFG_REGION_LAST:  last_q   <= cfg_data[ROW_W-1:0];
				CFG_OVL_ENABLE:   ovl_en_q <= cfg_data[0];
				CFG_BLEND_MODE:   blend_q  <= cfg_data[0];
				CFG_MIRROR:       mirror_q <= cfg_data[0];
				CFG_TRANSPARENT:  transp_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign width = (bw_q > WIDTH_MAX) ? WIDTH_MAX : bw_q;

	assign items.ready = !busy_q;
	assign acc         = items.valid && !busy_q;

	assign target  = $signed({3'b000, items.col}) + $signed({off_q[7], off_q});
	assign tgt_ok  = !target[8] && (target[7:0] < {1'b0, width});
	assign row_ok  = (items.row >= first_q) && (items.row <= last_q);
	assign wr_base = acc && items.kind == KIND_BASE && ({1'b0, items.col} < width);
	assign wr_ovl  = acc && items.kind == KIND_OVERLAY && ovl_en_q && row_ok && tgt_ok
		&& !(blend_q && items.symbol == transp_q);

	assign advance = busy_q && (!out_v_q || results.ready);
	assign last_w  = {1'b0, cnt_q} == (width - WIDTH_W'(1));

	assign ctrl.wr      = wr_base || wr_ovl;
	assign ctrl.wr_idx  = wr_base ? items.col : target[COL_W-1:0];
	assign ctrl.wr_data = items.symbol;
	assign ctrl.shl     = advance && !mirror_q;
	assign ctrl.shr     = advance && mirror_q;
	assign ctrl.width   = width;

	assign tail_idx = COL_W'(width - WIDTH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (acc && items.kind == KIND_EMIT && width != '0) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + COL_W'(1);
				if (last_w) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_col_q  <= cnt_q;
			out_sym_q  <= mirror_q ? tail : head;
			out_last_q <= last_w;
		end
	end

	assign results.valid      = out_v_q;
	assign results.out_col    = out_col_q;
	assign results.out_symbol = out_sym_q;
	assign results.out_last   = out_last_q;

endmodule

### rtl/srcm_checker.sv
// ----------------------------------------------------------------------------
// srcm_checker
// Port-level checks of the compositor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sprite_row_composite_mirror_macros.svh"

module srcm_checker
	import srcm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [COL_W-1:0] out_col,
	input logic             out_last
);

	`SRCM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "word dropped while stalled")
	`SRCM_ASSERT_NOW(a_busy_mid_row, clk, arst_n, out_valid && !out_last, !in_ready, "input taken mid row")
	`SRCM_ASSERT_NEXT(a_col_step, clk, arst_n, out_valid && out_ready && !out_last, out_valid && out_col == $past(out_col) + COL_W'(1), "row words not contiguous")

endmodule

bind sprite_row_composite_mirror srcm_checker u_srcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_col   (results.out_col),
	.out_last  (results.out_last)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sprite row compositor. A short scripted
// sequence covers clipping, row range, transparency, mirror and the empty
// row, then random rows built from base, overlay and stray words are checked
// word by word against a line buffer model kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import srcm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 80;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_WORDS = 430;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [SYM_W-1:0]  symbol;
	} cell_word_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} out_cell_t;

	typedef struct packed {
		logic                  is_reg;
		cell_word_t            word;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  typed;
		logic [2:0]            n_typed;
		logic [31:0]           typed_syms;
	} script_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	srcm_in_if  items_ch ();
	srcm_out_if cells_ch ();

	sprite_row_composite_mirror dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items_ch),
		.results  (cells_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// line buffer model and register copies
	logic [SYM_W-1:0]   line_cells [MAX_WIDTH];
	bit                 base_seen [MAX_WIDTH];
	logic [WIDTH_W-1:0] width_reg  = WIDTH_MAX;
	logic signed [7:0]  offset_reg = 8'sd0;
	logic [ROW_W-1:0]   first_reg  = 6'd0;
	logic [ROW_W-1:0]   last_reg   = 6'd63;
	logic               ovl_en_reg = 1'b0;
	logic               blend_reg  = 1'b1;
	logic               mirror_reg = 1'b0;
	logic [SYM_W-1:0]   transp_reg = 8'd32;

	out_cell_t pending_cells [$];
	int        fails        = 0;
	int        words_sent   = 0;
	bit        calm         = 1'b0;
	bit        hold_off_req = 1'b0;

	function automatic int row_width();
		return (width_reg > WIDTH_MAX) ? MAX_WIDTH : int'(width_reg);
	endfunction

	function automatic bit row_filled();
		for (int c = 0; c < row_width(); c++)
			if (!base_seen[c])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		CFG_BASE_WIDTH:   width_reg  = data[WIDTH_W-1:0];
		CFG_COL_OFFSET:   offset_reg = data;
		CFG_REGION_FIRST: first_reg  = data[ROW_W-1:0];
		CFG_REGION_LAST:  last_reg   = data[ROW_W-1:0];
		CFG_OVL_ENABLE:   ovl_en_reg = data[0];
		CFG_BLEND_MODE:   blend_reg  = data[0];
		CFG_MIRROR:       mirror_reg = data[0];
		CFG_TRANSPARENT:  transp_reg = data;
		default: ;
		endcase
	endfunction

	function automatic void composite_word(input cell_word_t w);
		int wd;
		int target;
		int src;
		wd = row_width();
		case (w.kind)
		KIND_BASE: begin
			if (int'(w.col) < wd) begin
				line_cells[w.col] = w.symbol;
				base_seen[w.col]  = 1'b1;
			end
		end
		KIND_OVERLAY: begin
			target = int'(w.col) + int'(offset_reg);
			if (ovl_en_reg && w.row >= first_reg && w.row <= last_reg &&
					target >= 0 && target < wd &&
					!(blend_reg && w.symbol == transp_reg))
				line_cells[COL_W'(target)] = w.symbol;
		end
		KIND_EMIT: begin
			for (int k = 0; k < wd; k++) begin
				src = mirror_reg ? wd - 1 - k : k;
				pending_cells.push_back(out_cell_t'{COL_W'(k),
					line_cells[COL_W'(src)], k == wd - 1});
			end
		end
		default: ;
		endcase
	endfunction

	function automatic script_step_t put_word(input logic [KIND_W-1:0] kind,
			input int r, input int c, input int s);
		script_step_t st;
		st = '0;
		st.word = cell_word_t'{kind, ROW_W'(r), COL_W'(c), SYM_W'(s)};
		return st;
	endfunction

	function automatic script_step_t set_reg(input logic [CFG_IDX_W-1:0] idx,
			input int d);
		script_step_t st;
		st = '0;
		st.is_reg = 1'b1;
		st.idx    = idx;
		st.data   = CFG_DATA_W'(d);
		return st;
	endfunction

	// syms holds cell k of the emitted row in byte k
	function automatic script_step_t emit_row(input int r, input int n,
			input logic [31:0] syms);
		script_step_t st;
		st = '0;
		st.word       = cell_word_t'{KIND_EMIT, ROW_W'(r), COL_W'(0), SYM_W'(0)};
		st.typed      = 1'b1;
		st.n_typed    = 3'(n);
		st.typed_syms = syms;
		return st;
	endfunction

	function automatic cell_word_t noise_word();
		cell_word_t w;
		w.kind   = KIND_W'($urandom_range(0, 3));
		w.row    = ROW_W'($urandom);
		w.col    = COL_W'($urandom);
		w.symbol = SYM_W'($urandom);
		if (w.kind == KIND_EMIT && !row_filled())
			w.kind = KIND_UNUSED;
		return w;
	endfunction

	function automatic cell_word_t overlay_word(input logic [ROW_W-1:0] r);
		cell_word_t w;
		int wd;
		int src;
		wd = row_width();
		w.kind   = KIND_OVERLAY;
		w.row    = ($urandom_range(0, 5) == 0) ? ROW_W'($urandom) : r;
		w.symbol = ($urandom_range(0, 4) == 0) ? transp_reg : SYM_W'($urandom);
		src = int'($urandom_range(0, (wd > 0) ? wd - 1 : 0)) - int'(offset_reg);
		w.col = (src >= 0 && src < MAX_WIDTH) ? COL_W'(src) : COL_W'($urandom);
		return w;
	endfunction

	task automatic offer_word(input cell_word_t w);
		int gap;
		gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
		repeat (gap) begin
			@(negedge clk);
			items_ch.valid <= 1'b0;
		end
		@(negedge clk);
		items_ch.valid  <= 1'b1;
		items_ch.kind   <= w.kind;
		items_ch.row    <= w.row;
		items_ch.col    <= w.col;
		items_ch.symbol <= w.symbol;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		if (w.kind != KIND_UNUSED)
			words_sent++;
	endtask

	task automatic send_and_predict(input cell_word_t w);
		offer_word(w);
		composite_word(w);
	endtask

	task automatic stop_offering();
		@(negedge clk);
		items_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_offering();
		while (pending_cells.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings(input int phase);
		logic [7:0] wv;
		logic [7:0] ov;
		logic [7:0] tv;
		int         f;
		int         l;
		case (phase)
		0: wv = 8'd64;
		1: wv = 8'hFF;
		2: wv = 8'd0;
		3: wv = 8'd1;
		default: wv = 8'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 5))
		0: ov = 8'hC0;
		1: ov = 8'd64;
		2: ov = 8'd0;
		default: ov = 8'($urandom_range(0, 128) - 64);
		endcase
		case ($urandom_range(0, 5))
		0: begin
			f = 0;
			l = 63;
		end
		1: begin
			f = $urandom_range(32, 63);
			l = $urandom_range(0, 31);
		end
		default: begin
			f = $urandom_range(0, 63);
			l = $urandom_range(f, 63);
		end
		endcase
		case ($urandom_range(0, 3))
		0: tv = 8'h00;
		1: tv = 8'hFF;
		default: tv = 8'($urandom);
		endcase
		write_reg(CFG_BASE_WIDTH, wv);
		write_reg(CFG_COL_OFFSET, ov);
		write_reg(CFG_REGION_FIRST, {2'($urandom), 6'(f)});
		write_reg(CFG_REGION_LAST, {2'($urandom), 6'(l)});
		write_reg(CFG_OVL_ENABLE, {7'($urandom), 1'($urandom_range(0, 3) != 0)});
		write_reg(CFG_BLEND_MODE, 8'($urandom));
		write_reg(CFG_MIRROR, 8'($urandom));
		write_reg(CFG_TRANSPARENT, tv);
	endtask

	task automatic random_row();
		int               wd;
		int               n_base;
		int               j;
		int               tmp;
		int               order [MAX_WIDTH];
		logic [ROW_W-1:0] rw;
		wd = row_width();
		if (first_reg <= last_reg && $urandom_range(0, 3) != 0)
			rw = ROW_W'($urandom_range(first_reg, last_reg));
		else
			rw = ROW_W'($urandom);
		for (int c = 0; c < wd; c++)
			order[c] = c;
		for (int i = wd - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		// once every column holds a base word, a row may refresh only some
		n_base = (row_filled() && $urandom_range(0, 1) == 1) ? $urandom_range(0, wd) : wd;
		for (int i = 0; i < n_base; i++) begin
			send_and_predict(cell_word_t'{KIND_BASE, rw, COL_W'(order[i]), SYM_W'($urandom)});
			case ($urandom_range(0, 7))
			0: send_and_predict(overlay_word(rw));
			1: send_and_predict(noise_word());
			default: ;
			endcase
		end
		repeat ($urandom_range(0, 4)) send_and_predict(overlay_word(rw));
		if (wd == 0)
			repeat (3) send_and_predict(noise_word());
		if (row_filled())
			send_and_predict(cell_word_t'{KIND_EMIT, rw, COL_W'($urandom), SYM_W'($urandom)});
	endtask

	initial begin
		script_step_t script [29];
		int           phase;
		int           n_rows;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = '0;
		cfg_data        = '0;
		items_ch.valid  = 1'b0;
		items_ch.kind   = '0;
		items_ch.row    = '0;
		items_ch.col    = '0;
		items_ch.symbol = '0;
		script = '{
			set_reg(CFG_BASE_WIDTH, 4),
			set_reg(CFG_COL_OFFSET, 8'hFF),
			set_reg(CFG_REGION_FIRST, 2),
			set_reg(CFG_REGION_LAST, 5),
			set_reg(CFG_OVL_ENABLE, 1),
			put_word(KIND_BASE, 0, 0, 8'h00),
			put_word(KIND_BASE, 0, 1, 8'hFF),
			put_word(KIND_BASE, 63, 2, 8'h41),
			put_word(KIND_BASE, 0, 3, 8'h42),
			put_word(KIND_BASE, 0, 63, 8'h99),
			put_word(KIND_OVERLAY, 2, 0, 8'h55),
			put_word(KIND_OVERLAY, 1, 2, 8'h66),
			put_word(KIND_OVERLAY, 6, 2, 8'h66),
			put_word(KIND_OVERLAY, 3, 2, 8'h20),
			put_word(KIND_UNUSED, 63, 63, 8'hFF),
			emit_row(0, 4, 32'h4241FF00),
			put_word(KIND_OVERLAY, 2, 5, 8'h77),
			put_word(KIND_OVERLAY, 5, 1, 8'h88),
			put_word(KIND_OVERLAY, 2, 4, 8'h99),
			emit_row(2, 4, 32'h9941FF88),
			set_reg(CFG_MIRROR, 1),
			set_reg(CFG_BLEND_MODE, 0),
			put_word(KIND_OVERLAY, 4, 2, 8'h20),
			emit_row(4, 4, 32'h88204199),
			set_reg(CFG_BASE_WIDTH, 0),
			put_word(KIND_BASE, 0, 0, 8'h11),
			emit_row(0, 0, 32'h0),
			set_reg(CFG_BASE_WIDTH, 4),
			emit_row(9, 4, 32'h88204199)
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_reg) begin
				wait_idle();
				write_reg(script[i].idx, script[i].data);
			end else begin
				offer_word(script[i].word);
				if (script[i].typed) begin
					for (int k = 0; k < int'(script[i].n_typed); k++)
						pending_cells.push_back(out_cell_t'{COL_W'(k),
							script[i].typed_syms[8*k +: 8],
							k == int'(script[i].n_typed) - 1});
				end else begin
					composite_word(script[i].word);
				end
			end
		end

		words_sent = 0;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			wait_idle();
			random_settings(phase);
			if (phase == 4)
				hold_off_req = 1'b1;
			n_rows = (row_width() > 8) ? 1 : $urandom_range(2, 5);
			repeat (n_rows) begin
				random_row();
				if ($urandom_range(0, 4) == 0)
					wait_drained();
				if (words_sent > RANDOM_WORDS - 60)
					calm = 1'b1;
			end
			phase++;
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// output side: random stall bursts, one long hold-off on request
	initial begin
		int stall;
		cells_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				cells_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 19);
				cells_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				cells_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_cells
		out_cell_t due;
		if (arst_n && cells_ch.valid && cells_ch.ready) begin
			if (pending_cells.size() == 0) begin
				$display("%0t: unexpected word col=%0d symbol=%02h last=%0b", $time,
					cells_ch.out_col, cells_ch.out_symbol, cells_ch.out_last);
				fails++;
			end else begin
				due = pending_cells.pop_front();
				if (cells_ch.out_col !== due.col) begin
					$display("%0t: out_col expected %0d got %0d", $time,
						due.col, cells_ch.out_col);
					fails++;
				end
				if (cells_ch.out_symbol !== due.symbol) begin
					$display("%0t: out_symbol expected %02h got %02h", $time,
						due.symbol, cells_ch.out_symbol);
					fails++;
				end
				if (cells_ch.out_last !== due.last) begin
					$display("%0t: out_last expected %0b got %0b", $time,
						due.last, cells_ch.out_last);
					fails++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/srcm_pkg.sv
rtl/srcm_if.sv
rtl/srcm_cell.sv
rtl/srcm_ctrl.sv
rtl/sprite_row_composite_mirror.sv
rtl/srcm_checker.sv
dv/testbench.sv
